// File: hdl/tsw_pkg.sv
// Package for the TCP sender window and retransmission core.
// Holds request and result types, controller commands, status and constants.
// No dependencies.
`default_nettype none
package tsw_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF       = 1452;
  localparam int unsigned OUTSTANDING_DEPTH_DEF = 64;
  localparam int unsigned RESULT_LIMIT          = 64;
  localparam int unsigned K_W                   = 7;
  localparam int unsigned CFG_IDX_W             = 8;
  localparam int unsigned CFG_DATA_W            = 32;
  localparam int unsigned PLEN_W                = 11;

  localparam logic [CFG_IDX_W-1:0] REG_ISN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INIT_RTO = CFG_IDX_W'(1);

  localparam logic [1:0] FUNC_FILL  = 2'd0;
  localparam logic [1:0] FUNC_ACK   = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ack_number;
    logic [15:0] adv_window;
    logic [15:0] elapsed_ms;
    logic [15:0] bytes_available;
    logic        input_ended;
  } tsw_in_t;

  typedef struct packed {
    logic        has_segment;
    logic [31:0] seqno;
    logic [31:0] stream_offset;
    logic [10:0] payload_length;
    logic        syn_flag;
    logic        fin_flag;
    logic        is_retransmit;
    logic [7:0]  retransmit_count;
    logic [31:0] unacked_bytes;
    logic        last;
  } tsw_out_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_UNWRAP,
    OP_ACKSUM,
    OP_POP,
    OP_FRESH,
    OP_EDGE,
    OP_ROOM,
    OP_TAKE,
    OP_SEND,
    OP_EMPTY,
    OP_NOSEG,
    OP_TADD,
    OP_RETX,
    OP_EMIT
  } tsw_op_e;

  typedef enum logic [1:0] {
    LEN_ZERO,
    LEN_MAX,
    LEN_REM
  } tsw_len_e;

  typedef struct packed {
    tsw_op_e  op;
    tsw_len_e len_sel;
    logic     syn;
    logic     fin;
    logic     last;
  } tsw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       next_zero;
    logic       next_is_fin;
    logic       ack_bad;
    logic       pop_ok;
    logic       cnt_zero;
    logic       cnt_full;
    logic       cnt_near_full;
    logic       rem_gt_max;
    logic       rem_nz;
    logic       fin_take;
    logic       timer_hit;
    logic       out_free;
  } tsw_sts_t;

endpackage
`default_nettype wire

// File: hdl/tsw_dp.sv
// Datapath of the TCP sender core: sequence state, segment queue memory,
// timer, configuration registers and the result register. Uses tsw_pkg.
`default_nettype none
module tsw_dp import tsw_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD       = MAX_PAYLOAD_DEF,
  parameter int unsigned OUTSTANDING_DEPTH = OUTSTANDING_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_accept_i,
  input  wire tsw_in_t               in_req_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire tsw_cmd_t              cmd_i,
  output tsw_sts_t                   sts_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output tsw_out_t                   out_rsp_o
);

  localparam int unsigned PTR_W = $clog2(OUTSTANDING_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUTSTANDING_DEPTH + 1);

  logic [31:0] isn_q;
  logic [15:0] irto_q;
  tsw_in_t     item_q;

  logic [63:0] next_q, acked_q, wre_q, fin_end_q;
  logic [PTR_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] count_q;
  logic [31:0] rto_q, timer_q;
  logic [7:0]  retx_q;

  logic [31:0] d_q;
  logic [63:0] ack_q, edge_eff_q, room_q, start_q;
  logic        fresh_q;
  logic [15:0] rem_q;
  logic        fin_take_q;
  logic [PLEN_W-1:0] plen_q;
  logic        seg_f_q, syn_f_q, fin_f_q, retx_f_q;

  logic [63:0] mem_q [OUTSTANDING_DEPTH];
  logic [63:0] rd_q;

  tsw_out_t out_q;
  logic     out_valid_q;

  logic [PLEN_W-1:0] send_len;
  logic [63:0] send_next;
  logic [63:0] ack_sum, ack_edge;
  logic [32:0] timer_sum;
  logic        retx_syn, retx_fin;
  logic [63:0] retx_plen;
  logic        out_free;

  always_comb begin
    case (cmd_i.len_sel)
      LEN_MAX: send_len = PLEN_W'(MAX_PAYLOAD);
      LEN_REM: send_len = rem_q[PLEN_W-1:0];
      default: send_len = '0;
    endcase
  end

  assign send_next = next_q + 64'(send_len) + 64'(cmd_i.syn) + 64'(cmd_i.fin);
  assign ack_sum   = next_q + {32'd0, d_q};
  assign ack_edge  = ack_q + {48'd0, item_q.adv_window};
  assign timer_sum = {1'b0, timer_q} + {17'd0, item_q.elapsed_ms};
  assign retx_syn  = (acked_q == 64'd0);
  assign retx_fin  = (rd_q == fin_end_q);
  assign retx_plen = rd_q - acked_q - 64'(retx_syn) - 64'(retx_fin);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o.func          = item_q.func;
    sts_o.next_zero     = (next_q == 64'd0);
    sts_o.next_is_fin   = (next_q == fin_end_q);
    sts_o.ack_bad       = (ack_q > next_q) || (ack_q < acked_q);
    sts_o.pop_ok        = (count_q != '0) && (rd_q <= ack_q);
    sts_o.cnt_zero      = (count_q == '0);
    sts_o.cnt_full      = (count_q == CNT_W'(OUTSTANDING_DEPTH));
    sts_o.cnt_near_full = (count_q == CNT_W'(OUTSTANDING_DEPTH - 1));
    sts_o.rem_gt_max    = (rem_q > 16'(MAX_PAYLOAD));
    sts_o.rem_nz        = (rem_q != 16'd0);
    sts_o.fin_take      = fin_take_q;
    sts_o.timer_hit     = (timer_q >= rto_q);
    sts_o.out_free      = out_free;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[head_q];
    if (cmd_i.op == OP_SEND) begin
      mem_q[tail_q] <= send_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isn_q       <= '0;
      irto_q      <= 16'd1000;
      next_q      <= '0;
      acked_q     <= '0;
      wre_q       <= '0;
      fin_end_q   <= '1;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rto_q       <= 32'd1000;
      timer_q     <= '0;
      retx_q      <= '0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ISN: isn_q <= cfg_data_i;
          REG_INIT_RTO: begin
            irto_q <= cfg_data_i[15:0];
            rto_q  <= {16'd0, cfg_data_i[15:0]};
          end
          default: ;
        endcase
      end
      if (in_accept_i) begin
        fresh_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i && cmd_i.op != OP_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_POP: begin
          if (sts_o.pop_ok) begin
            acked_q <= rd_q;
            head_q  <= (head_q == PTR_W'(OUTSTANDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
            count_q <= count_q - 1'b1;
            fresh_q <= 1'b1;
          end
        end
        OP_FRESH: begin
          if (fresh_q) begin
            rto_q   <= {16'd0, irto_q};
            retx_q  <= '0;
            timer_q <= '0;
          end
          if (ack_edge > wre_q) begin
            wre_q <= ack_edge;
          end
        end
        OP_SEND: begin
          next_q  <= send_next;
          tail_q  <= (tail_q == PTR_W'(OUTSTANDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          count_q <= count_q + 1'b1;
          if (cmd_i.fin) begin
            fin_end_q <= send_next;
          end
        end
        OP_TADD: begin
          timer_q <= timer_sum[32] ? '1 : timer_sum[31:0];
        end
        OP_RETX: begin
          if (wre_q != acked_q) begin
            if (retx_q != 8'hFF) begin
              retx_q <= retx_q + 1'b1;
            end
            rto_q <= rto_q[31] ? '1 : {rto_q[30:0], 1'b0};
          end
          timer_q <= '0;
        end
        OP_EMIT: begin
          out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      item_q <= in_req_i;
    end
    case (cmd_i.op)
      OP_UNWRAP: d_q <= item_q.ack_number - isn_q - next_q[31:0];
      OP_ACKSUM: ack_q <= (d_q[31] && ack_sum[63:32] != 32'd0) ?
                          ack_sum - 64'h1_0000_0000 : ack_sum;
      OP_EDGE: edge_eff_q <= wre_q +
                             64'((item_q.func == FUNC_ACK) && (item_q.adv_window == 16'd0));
      OP_ROOM: room_q <= (edge_eff_q > next_q) ? edge_eff_q - next_q : 64'd0;
      OP_TAKE: begin
        if (room_q > {48'd0, item_q.bytes_available}) begin
          rem_q      <= item_q.bytes_available;
          fin_take_q <= item_q.input_ended;
        end else begin
          rem_q      <= room_q[15:0];
          fin_take_q <= 1'b0;
        end
      end
      OP_SEND: begin
        start_q  <= next_q;
        plen_q   <= send_len;
        seg_f_q  <= 1'b1;
        syn_f_q  <= cmd_i.syn;
        fin_f_q  <= cmd_i.fin;
        retx_f_q <= 1'b0;
        if (cmd_i.len_sel == LEN_MAX) begin
          rem_q <= rem_q - 16'(MAX_PAYLOAD);
        end
      end
      OP_EMPTY: begin
        start_q  <= next_q;
        plen_q   <= '0;
        seg_f_q  <= 1'b1;
        syn_f_q  <= 1'b0;
        fin_f_q  <= 1'b0;
        retx_f_q <= 1'b0;
      end
      OP_NOSEG: begin
        start_q  <= '0;
        plen_q   <= '0;
        seg_f_q  <= 1'b0;
        syn_f_q  <= 1'b0;
        fin_f_q  <= 1'b0;
        retx_f_q <= 1'b0;
      end
      OP_RETX: begin
        start_q  <= acked_q;
        plen_q   <= retx_plen[PLEN_W-1:0];
        seg_f_q  <= 1'b1;
        syn_f_q  <= retx_syn;
        fin_f_q  <= retx_fin;
        retx_f_q <= 1'b1;
      end
      OP_EMIT: begin
        out_q.has_segment      <= seg_f_q;
        out_q.seqno            <= seg_f_q ? start_q[31:0] + isn_q : 32'd0;
        out_q.stream_offset    <= (seg_f_q && start_q != 64'd0) ?
                                  start_q[31:0] - 32'd1 : 32'd0;
        out_q.payload_length   <= seg_f_q ? plen_q : '0;
        out_q.syn_flag         <= seg_f_q && syn_f_q;
        out_q.fin_flag         <= seg_f_q && fin_f_q;
        out_q.is_retransmit    <= seg_f_q && retx_f_q;
        out_q.retransmit_count <= retx_q;
        out_q.unacked_bytes    <= next_q[31:0] - acked_q[31:0];
        out_q.last             <= cmd_i.last;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire

// File: hdl/tsw_ctrl.sv
// Controller state machine of the TCP sender core.
// Sequences datapath operations per request; uses tsw_pkg.
`default_nettype none
module tsw_ctrl import tsw_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_accept_i,
  input  wire tsw_sts_t sts_i,
  output logic          idle_o,
  output tsw_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_UNWRAP, S_ACKSUM, S_ACKCHK, S_POP, S_POPWAIT,
    S_FRESH, S_EDGE, S_FCHK, S_ROOM, S_TAKE, S_SEG, S_EMIT,
    S_TWAIT, S_TADD, S_TCHK, S_EMPTY
  } state_e;

  state_e       state_q;
  logic [K_W-1:0] k_q;
  logic         more_q;

  logic can_send, can_next;
  assign can_send = !sts_i.cnt_full && (k_q < K_W'(RESULT_LIMIT));
  assign can_next = !sts_i.cnt_near_full && (k_q < K_W'(RESULT_LIMIT - 1));
  assign idle_o   = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '{op: OP_IDLE, len_sel: LEN_ZERO, syn: 1'b0, fin: 1'b0, last: !more_q};
    unique case (state_q)
      S_UNWRAP: cmd_o.op = OP_UNWRAP;
      S_ACKSUM: cmd_o.op = OP_ACKSUM;
      S_ACKCHK: if (sts_i.ack_bad) cmd_o.op = OP_NOSEG;
      S_POP:    cmd_o.op = OP_POP;
      S_FRESH:  cmd_o.op = OP_FRESH;
      S_EDGE:   cmd_o.op = OP_EDGE;
      S_ROOM:   cmd_o.op = OP_ROOM;
      S_TAKE:   cmd_o.op = OP_TAKE;
      S_FCHK, S_EMPTY: begin
        if (state_q == S_FCHK && sts_i.next_is_fin) begin
          cmd_o.op = OP_NOSEG;
        end else if (sts_i.next_zero) begin
          if (can_send) begin
            cmd_o.op  = OP_SEND;
            cmd_o.syn = 1'b1;
          end else begin
            cmd_o.op = OP_NOSEG;
          end
        end else if (state_q == S_EMPTY) begin
          cmd_o.op = OP_EMPTY;
        end
      end
      S_SEG: begin
        if (sts_i.rem_gt_max) begin
          if (can_send) begin
            cmd_o.op      = OP_SEND;
            cmd_o.len_sel = LEN_MAX;
          end else begin
            cmd_o.op = OP_NOSEG;
          end
        end else if ((sts_i.rem_nz || sts_i.fin_take) && can_send) begin
          cmd_o.op      = OP_SEND;
          cmd_o.len_sel = LEN_REM;
          cmd_o.fin     = sts_i.fin_take;
        end else begin
          cmd_o.op = OP_NOSEG;
        end
      end
      S_EMIT:   if (sts_i.out_free) cmd_o.op = OP_EMIT;
      S_TADD:   cmd_o.op = sts_i.cnt_zero ? OP_NOSEG : OP_TADD;
      S_TCHK:   cmd_o.op = sts_i.timer_hit ? OP_RETX : OP_NOSEG;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      more_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          k_q    <= '0;
          more_q <= 1'b0;
          if (in_accept_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (sts_i.func)
            FUNC_ACK:  state_q <= S_UNWRAP;
            FUNC_TICK: state_q <= S_TWAIT;
            FUNC_EMPTY: state_q <= S_EMPTY;
            default:   state_q <= S_EDGE;
          endcase
        end
        S_UNWRAP: state_q <= S_ACKSUM;
        S_ACKSUM: state_q <= S_ACKCHK;
        S_ACKCHK: state_q <= sts_i.ack_bad ? S_EMIT : S_POP;
        S_POP:    state_q <= sts_i.pop_ok ? S_POPWAIT : S_FRESH;
        S_POPWAIT: state_q <= S_POP;
        S_FRESH:  state_q <= S_EDGE;
        S_EDGE:   state_q <= S_FCHK;
        S_FCHK: begin
          if (sts_i.next_is_fin || sts_i.next_zero) begin
            more_q  <= 1'b0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_ROOM;
          end
        end
        S_ROOM: state_q <= S_TAKE;
        S_TAKE: state_q <= S_SEG;
        S_SEG: begin
          if (cmd_o.op == OP_SEND) begin
            k_q    <= k_q + 1'b1;
            more_q <= (cmd_o.len_sel == LEN_MAX) && can_next;
          end else begin
            more_q <= 1'b0;
          end
          state_q <= (cmd_o.op == OP_SEND || k_q == '0) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (sts_i.out_free) state_q <= more_q ? S_SEG : S_IDLE;
        end
        S_TWAIT: state_q <= S_TADD;
        S_TADD:  state_q <= sts_i.cnt_zero ? S_EMIT : S_TCHK;
        S_TCHK:  state_q <= S_EMIT;
        S_EMPTY: begin
          more_q  <= 1'b0;
          state_q <= S_EMIT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/tcp_sender_window_retransmit_core.sv
// Top level of the TCP sender window and retransmission core.
// Connects tsw_ctrl and tsw_dp; uses tsw_pkg.
// Usage: requests enter on the in channel (valid/stall) as tsw_in_t items:
// fill window, acknowledgement, timer tick or empty-ack. Each request gives
// one or more tsw_out_t results on the out channel; the final one has last
// set. A request that sends nothing yields one result with has_segment 0.
// Configuration (ISN at index 0, initial RTO at index 1) must be written on the
// cfg channel only while the core is idle, which the core does not enforce;
// cfg_ready_o is always high. A fill that is not just the SYN and does not
// follow the FIN works out the window room and sends its segments in turn;
// an acknowledgement first pops the acked queue entries one at a time, and
// a rejected one goes straight to its result. One request is handled at a
// time, and the next one is taken in the cycle after the final result is
// loaded.
// While the receiver stalls, the core holds the result and waits before
// loading the next one; in_stall_o stays high until the final one is loaded.
// Reset clears the sequence state (the FIN end goes to all ones), the queue pointers and the timer, and
// loads ISN 0 and an RTO of 1000 ms; the queue memory needs no clearing.
`default_nettype none
module tcp_sender_window_retransmit_core import tsw_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD       = MAX_PAYLOAD_DEF,
  parameter int unsigned OUTSTANDING_DEPTH = OUTSTANDING_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire tsw_in_t               in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output tsw_out_t                   out_rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  tsw_cmd_t cmd;
  tsw_sts_t sts;
  logic     idle;
  logic     in_accept;

  assign in_stall_o  = !idle;
  assign in_accept   = in_valid_i && idle;
  assign cfg_ready_o = 1'b1;

  tsw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .sts_i       (sts),
    .idle_o      (idle),
    .cmd_o       (cmd)
  );

  tsw_dp #(
    .MAX_PAYLOAD       (MAX_PAYLOAD),
    .OUTSTANDING_DEPTH (OUTSTANDING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for tcp_sender_window_retransmit_core.
// Holds a sequence-space predictor of the sender, a queue-fed driver and a monitor.
// Depends on tsw_pkg and the core RTL.
`default_nettype none
module testbench;
  import tsw_pkg::*;

  localparam int unsigned SEG_MAX = 1452;
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned IDLE_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tsw_in_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tsw_out_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcp_sender_window_retransmit_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // Shadow state of the sender.
  logic [63:0] snd_nxt, snd_una, wnd_edge, fin_seq;
  logic [63:0] unacked_end [RING_DEPTH];
  int unsigned ring_head, ring_cnt;
  logic [31:0] rto, tmr, isn_r;
  logic [15:0] init_rto;
  logic [7:0] retx_cnt;

  tsw_in_t pending_req[$];
  tsw_out_t want_rsp[$];
  int unsigned n_sent = 0, n_taken = 0;
  int unsigned fail_cnt = 0, idle_cnt = 0;
  int unsigned req_gap = 0, rsp_gap = 0;
  bit no_idle = 1'b0, took = 1'b0, fin_ok = 1'b0;

  function automatic tsw_out_t seg_rsp(bit seg, logic [63:0] start, logic [63:0] plen,
                                       bit syn, bit fin, bit retx);
    tsw_out_t r;
    logic [63:0] off;
    off = start - 64'd1;
    r = '0;
    r.has_segment = seg;
    r.seqno = seg ? start[31:0] + isn_r : 32'd0;
    r.stream_offset = (seg && start != 64'd0) ? off[31:0] : 32'd0;
    r.payload_length = seg ? plen[10:0] : 11'd0;
    r.syn_flag = seg && syn;
    r.fin_flag = seg && fin;
    r.is_retransmit = seg && retx;
    r.retransmit_count = retx_cnt;
    off = snd_nxt - snd_una;
    r.unacked_bytes = off[31:0];
    return r;
  endfunction

  function automatic void send_seg(ref tsw_out_t batch[$], input logic [63:0] plen,
                                   input bit syn, input bit fin);
    logic [63:0] start;
    start = snd_nxt;
    snd_nxt = start + plen + syn + fin;
    unacked_end[(ring_head + ring_cnt) % RING_DEPTH] = snd_nxt;
    ring_cnt++;
    batch.insert(batch.size(), seg_rsp(1'b1, start, plen, syn, fin, 1'b0));
  endfunction

  function automatic bit room_left(int unsigned k);
    return ring_cnt < RING_DEPTH && k < RESULT_LIMIT;
  endfunction

  function automatic void fill_wnd(ref tsw_out_t batch[$], input logic [63:0] avail,
                                   input bit ended);
    logic [63:0] room, take, pos;
    bit fin;
    pos = 0;
    if (snd_nxt == fin_seq) return;
    if (snd_nxt == 64'd0) begin
      if (room_left(batch.size())) send_seg(batch, 64'd0, 1'b1, 1'b0);
      return;
    end
    room = wnd_edge > snd_nxt ? wnd_edge - snd_nxt : 64'd0;
    take = avail < room ? avail : room;
    fin = ended && take < room;
    while (take - pos > SEG_MAX) begin
      if (!room_left(batch.size())) return;
      send_seg(batch, SEG_MAX, 1'b0, 1'b0);
      pos += SEG_MAX;
    end
    if ((pos < take || fin) && room_left(batch.size())) begin
      send_seg(batch, take - pos, 1'b0, fin);
      if (fin) fin_seq = snd_nxt;
    end
  endfunction

  function automatic logic [63:0] abs_ack(logic [31:0] wrapped);
    logic [31:0] d;
    logic [63:0] back;
    d = wrapped - isn_r - snd_nxt[31:0];
    if (d < 32'h8000_0000) return snd_nxt + d;
    back = 64'h1_0000_0000 - d;
    if (snd_nxt >= back) return snd_nxt - back;
    return snd_nxt + d;
  endfunction

  function automatic void predict(tsw_in_t req);
    tsw_out_t batch[$];
    logic [63:0] ack, hi, start, plen;
    bit fresh, syn, fin;
    fresh = 1'b0;
    case (req.func)
      FUNC_FILL: fill_wnd(batch, req.bytes_available, req.input_ended);
      FUNC_ACK: begin
        ack = abs_ack(req.ack_number);
        if (!(ack > snd_nxt || ack < snd_una)) begin
          while (ring_cnt > 0 && unacked_end[ring_head] <= ack) begin
            snd_una = unacked_end[ring_head];
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_cnt--;
            fresh = 1'b1;
          end
          if (fresh) begin
            rto = init_rto;
            retx_cnt = '0;
            tmr = '0;
          end
          hi = ack + req.adv_window;
          if (hi > wnd_edge) wnd_edge = hi;
          if (req.adv_window == 16'd0) wnd_edge++;
          fill_wnd(batch, req.bytes_available, req.input_ended);
          if (req.adv_window == 16'd0) wnd_edge--;
        end
      end
      FUNC_TICK: begin
        if (ring_cnt > 0) begin
          tmr = (tmr > 32'hFFFF_FFFF - req.elapsed_ms) ? 32'hFFFF_FFFF : tmr + req.elapsed_ms;
          if (tmr >= rto) begin
            start = snd_una;
            syn = (start == 64'd0);
            fin = (unacked_end[ring_head] == fin_seq);
            plen = unacked_end[ring_head] - start - syn - fin;
            if (wnd_edge != snd_una) begin
              if (retx_cnt != 8'hFF) retx_cnt++;
              rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto << 1;
            end
            tmr = '0;
            batch.insert(batch.size(), seg_rsp(1'b1, start, plen, syn, fin, 1'b1));
          end
        end
      end
      default: begin
        if (snd_nxt == 64'd0) begin
          if (room_left(0)) send_seg(batch, 64'd0, 1'b1, 1'b0);
        end else begin
          batch.insert(batch.size(), seg_rsp(1'b1, snd_nxt, 64'd0, 1'b0, 1'b0, 1'b0));
        end
      end
    endcase
    if (batch.size() == 0) begin
      batch.insert(0, seg_rsp(1'b0, 64'd0, 64'd0, 1'b0, 1'b0, 1'b0));
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) want_rsp.insert(want_rsp.size(), batch[i]);
  endfunction

  // Request side: sample acceptance, then drive at the falling edge.
  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      predict(in_req);
      n_taken++;
      took = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic v;
    v = in_valid && !took;
    if (!v) begin
      if (req_gap > 0) begin
        req_gap--;
      end else if (pending_req.size() > 0) begin
        in_req <= pending_req[0];
        pending_req.delete(0);
        v = 1'b1;
        req_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
    end
    took = 1'b0;
    in_valid <= v;
  end

  // Result side: stall for a drawn number of cycles before each result.
  always @(negedge clk_i) begin
    if (rsp_gap > 0) begin
      rsp_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    tsw_out_t e;
    if (out_valid && !out_stall) begin
      rsp_gap = no_idle ? 0 : $urandom_range(0, 4);
      if (want_rsp.size() == 0) begin
        $error("unexpected result %p", out_rsp);
        fail_cnt++;
      end else begin
        e = want_rsp[0];
        want_rsp.delete(0);
        if (out_rsp.has_segment !== e.has_segment) begin
          $error("has_segment exp %0d got %0d", e.has_segment, out_rsp.has_segment);
          fail_cnt++;
        end
        if (out_rsp.seqno !== e.seqno) begin
          $error("seqno exp %h got %h", e.seqno, out_rsp.seqno);
          fail_cnt++;
        end
        if (out_rsp.stream_offset !== e.stream_offset) begin
          $error("stream_offset exp %h got %h", e.stream_offset, out_rsp.stream_offset);
          fail_cnt++;
        end
        if (out_rsp.payload_length !== e.payload_length) begin
          $error("payload_length exp %0d got %0d", e.payload_length, out_rsp.payload_length);
          fail_cnt++;
        end
        if (out_rsp.syn_flag !== e.syn_flag) begin
          $error("syn_flag exp %0d got %0d", e.syn_flag, out_rsp.syn_flag);
          fail_cnt++;
        end
        if (out_rsp.fin_flag !== e.fin_flag) begin
          $error("fin_flag exp %0d got %0d", e.fin_flag, out_rsp.fin_flag);
          fail_cnt++;
        end
        if (out_rsp.is_retransmit !== e.is_retransmit) begin
          $error("is_retransmit exp %0d got %0d", e.is_retransmit, out_rsp.is_retransmit);
          fail_cnt++;
        end
        if (out_rsp.retransmit_count !== e.retransmit_count) begin
          $error("retransmit_count exp %0d got %0d", e.retransmit_count,
                 out_rsp.retransmit_count);
          fail_cnt++;
        end
        if (out_rsp.unacked_bytes !== e.unacked_bytes) begin
          $error("unacked_bytes exp %h got %h", e.unacked_bytes, out_rsp.unacked_bytes);
          fail_cnt++;
        end
        if (out_rsp.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_rsp.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic issue(input logic [1:0] func, input logic [31:0] ackno,
                       input logic [15:0] win, input logic [15:0] el,
                       input logic [15:0] avail, input bit ended);
    tsw_in_t r;
    r.func = func;
    r.ack_number = ackno;
    r.adv_window = win;
    r.elapsed_ms = el;
    r.bytes_available = avail;
    r.input_ended = ended;
    pending_req.insert(pending_req.size(), r);
    n_sent++;
    wait (n_taken == n_sent);
  endtask

  function automatic logic [31:0] wrap(logic [63:0] a);
    return a[31:0] + isn_r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_ISN) begin
      isn_r = val;
    end else if (idx == REG_INIT_RTO) begin
      init_rto = val[15:0];
      rto = val[15:0];
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    wait (n_taken == n_sent && want_rsp.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_req();
    logic [63:0] a;
    logic [15:0] win, avail;
    int unsigned p;
    p = $urandom_range(0, 99);
    win = ($urandom_range(0, 9) == 0) ? 16'd0 :
          ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 8000));
    avail = ($urandom_range(0, 9) == 0) ? 16'd0 :
            ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 5000));
    if (p < 5) begin
      issue(2'($urandom), $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (p < 33) begin
      issue(FUNC_FILL, $urandom, 16'($urandom), 16'($urandom), avail,
            fin_ok && $urandom_range(0, 29) == 0);
    end else if (p < 70) begin
      if ($urandom_range(0, 9) == 0) begin
        a = {32'd0, $urandom};
        issue(FUNC_ACK, a[31:0], win, 16'($urandom), avail, 1'b0);
      end else begin
        case ($urandom_range(0, 3))
          0: a = snd_nxt;
          1: a = snd_una;
          default: a = ring_cnt > 0 ?
                       unacked_end[(ring_head + $urandom_range(0, ring_cnt - 1)) % RING_DEPTH]
                       : snd_nxt;
        endcase
        issue(FUNC_ACK, wrap(a), win, 16'($urandom), avail,
              fin_ok && $urandom_range(0, 29) == 0);
      end
    end else if (p < 90) begin
      issue(FUNC_TICK, $urandom, 16'($urandom),
            ($urandom_range(0, 6) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2000)),
            16'($urandom), 1'($urandom));
    end else begin
      issue(FUNC_EMPTY, $urandom, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    snd_nxt = '0;
    snd_una = '0;
    wnd_edge = '0;
    fin_seq = '1;
    ring_head = 0;
    ring_cnt = 0;
    init_rto = 16'd1000;
    rto = 32'd1000;
    tmr = '0;
    isn_r = '0;
    retx_cnt = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed opening: ignored tick, SYN by empty ack, closed window, bad ack,
    // big fills hitting the result limit and a full queue, timeouts, zero window.
    write_reg(REG_ISN, 32'hFFFF_FFF0);
    write_reg(REG_INIT_RTO, 32'd1);
    issue(FUNC_TICK, 0, 0, 16'hFFFF, 0, 1'b0);
    issue(FUNC_EMPTY, 0, 0, 0, 0, 1'b0);
    issue(FUNC_EMPTY, 0, 0, 0, 0, 1'b0);
    issue(FUNC_FILL, 0, 0, 0, 16'hFFFF, 1'b0);
    issue(FUNC_ACK, wrap(snd_nxt + 5), 16'hFFFF, 0, 16'hFFFF, 1'b0);
    issue(FUNC_TICK, 0, 0, 16'd0, 0, 1'b0);
    issue(FUNC_TICK, 0, 0, 16'd1, 0, 1'b0);
    issue(FUNC_ACK, wrap(64'd1), 16'hFFFF, 0, 16'hFFFF, 1'b0);
    issue(FUNC_ACK, wrap(snd_una), 16'hFFFF, 0, 16'hFFFF, 1'b0);
    issue(FUNC_FILL, 0, 0, 0, 16'hFFFF, 1'b0);
    issue(FUNC_ACK, wrap(snd_una + 64'd10000), 16'hFFFF, 0, 16'hFFFF, 1'b0);
    issue(FUNC_FILL, 0, 0, 0, 16'hFFFF, 1'b0);
    issue(FUNC_EMPTY, 0, 0, 0, 0, 1'b0);
    issue(FUNC_TICK, 0, 0, 16'hFFFF, 0, 1'b0);
    issue(FUNC_TICK, 0, 0, 16'hFFFF, 0, 1'b0);
    issue(FUNC_ACK, wrap(snd_nxt), 16'd0, 0, 16'd100, 1'b0);
    issue(FUNC_ACK, wrap(snd_nxt), 16'd0, 0, 16'd100, 1'b0);
    issue(FUNC_TICK, 0, 0, 16'hFFFF, 0, 1'b0);
    issue(FUNC_ACK, wrap(snd_nxt), 16'd3000, 0, 16'd2904, 1'b0);
    issue(FUNC_ACK, $urandom, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_ISN, $urandom);
          write_reg(REG_INIT_RTO, 32'd1000);
        end
        1: begin
          write_reg(REG_ISN, 32'd0);
          write_reg(REG_INIT_RTO, 32'hFFFF);
          write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
        end
        2: begin
          write_reg(REG_ISN, 32'hFFFF_FFFF);
          write_reg(REG_INIT_RTO, 32'd1);
        end
        default: begin
          write_reg(REG_ISN, $urandom);
          write_reg(REG_INIT_RTO, 32'($urandom_range(1, 65535)));
          fin_ok = 1'b1;
        end
      endcase
      for (int i = 0; i < 98; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        random_req();
      end
    end
    no_idle = 1'b0;
    settle();
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
